// ===== rtl/core/lsepg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the LED strip effect pixel generator.
package lsepg_pkg;

  typedef enum logic [2:0] {
    REQ_AMBIENT     = 3'd0,
    REQ_NAV_LEFT    = 3'd1,
    REQ_NAV_RIGHT   = 3'd2,
    REQ_STRAIGHT    = 3'd3,
    REQ_BLINK_LEFT  = 3'd4,
    REQ_BLINK_RIGHT = 3'd5,
    REQ_HAZARD      = 3'd6
  } req_type_t;

  // Which period the elapsed time is reduced by.
  typedef enum logic [1:0] {
    PER_3000 = 2'd0,
    PER_1050 = 2'd1,
    PER_800  = 2'd2
  } per_sel_t;

  localparam logic [11:0] PERIOD_AMBIENT  = 12'd3000;
  localparam logic [11:0] PERIOD_NAV      = 12'd1050;
  localparam logic [11:0] PERIOD_STRAIGHT = 12'd800;
  localparam logic [11:0] NAV_SLIDE_MS    = 12'd819;
  localparam logic [11:0] BLINK_ON_MS     = 12'd200;
  localparam logic [11:0] BLINK_HALF_MS   = 12'd400;

  // Byte weights 2^16 and 2^24 reduced by each period.
  localparam logic [11:0] RES2_3000 = 12'((64'd1 << 16) % 64'd3000);
  localparam logic [11:0] RES3_3000 = 12'((64'd1 << 24) % 64'd3000);
  localparam logic [11:0] RES2_1050 = 12'((64'd1 << 16) % 64'd1050);
  localparam logic [11:0] RES3_1050 = 12'((64'd1 << 24) % 64'd1050);
  localparam logic [11:0] RES2_800  = 12'((64'd1 << 16) % 64'd800);
  localparam logic [11:0] RES3_800  = 12'((64'd1 << 24) % 64'd800);

  // floor(2^32 / P): quotient estimate, low by at most one.
  localparam logic [22:0] RCP_3000 = 23'((64'd1 << 32) / 64'd3000);
  localparam logic [22:0] RCP_1050 = 23'((64'd1 << 32) / 64'd1050);
  localparam logic [22:0] RCP_800  = 23'((64'd1 << 32) / 64'd800);

  // ceil(2^40 / D): exact floor(x * 65536 / D) for x below D via a shift by 24.
  localparam logic [32:0] FRC_3000 = 33'(((64'd1 << 40) + 64'd2999) / 64'd3000);
  localparam logic [32:0] FRC_800  = 33'(((64'd1 << 40) + 64'd799) / 64'd800);
  localparam logic [32:0] FRC_819  = 33'(((64'd1 << 40) + 64'd818) / 64'd819);
  localparam logic [32:0] FRC_231  = 33'(((64'd1 << 40) + 64'd230) / 64'd231);

  // ceil(2^32 / 9): exact floor(dist * 256 / 9) for the bar distances in use.
  localparam logic [28:0] CT_RCP = 29'(((64'd1 << 32) + 64'd8) / 64'd9);

  localparam int unsigned STAGES = 11;

  function automatic logic [11:0] period_of(input per_sel_t sel);
    logic [11:0] p;
    case (sel)
      PER_3000: p = PERIOD_AMBIENT;
      PER_1050: p = PERIOD_NAV;
      default:  p = PERIOD_STRAIGHT;
    endcase
    return p;
  endfunction

  function automatic logic [11:0] res2_of(input per_sel_t sel);
    logic [11:0] r;
    case (sel)
      PER_3000: r = RES2_3000;
      PER_1050: r = RES2_1050;
      default:  r = RES2_800;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] res3_of(input per_sel_t sel);
    logic [11:0] r;
    case (sel)
      PER_3000: r = RES3_3000;
      PER_1050: r = RES3_1050;
      default:  r = RES3_800;
    endcase
    return r;
  endfunction

  function automatic logic [22:0] rcp_of(input per_sel_t sel);
    logic [22:0] r;
    case (sel)
      PER_3000: r = RCP_3000;
      PER_1050: r = RCP_1050;
      default:  r = RCP_800;
    endcase
    return r;
  endfunction

  // Quarter-wave sine table, 32767 is one.
  function automatic logic [14:0] qsine(input logic [4:0] i);
    logic [14:0] v;
    case (i)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd3212;
      5'd2:    v = 15'd6393;
      5'd3:    v = 15'd9512;
      5'd4:    v = 15'd12539;
      5'd5:    v = 15'd15446;
      5'd6:    v = 15'd18204;
      5'd7:    v = 15'd20787;
      5'd8:    v = 15'd23170;
      5'd9:    v = 15'd25329;
      5'd10:   v = 15'd27245;
      5'd11:   v = 15'd28898;
      5'd12:   v = 15'd30273;
      5'd13:   v = 15'd31356;
      5'd14:   v = 15'd32137;
      5'd15:   v = 15'd32609;
      5'd16:   v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Q0.16 turn in, Q1.15 sine out, interpolated with ten fraction bits.
  function automatic logic signed [16:0] sine_q15(input logic [15:0] a);
    logic [1:0]  quad;
    logic [14:0] p;
    logic [4:0]  i;
    logic [14:0] v0;
    logic [14:0] v1;
    logic [24:0] prod;
    logic [15:0] v;
    quad = a[15:14];
    p    = quad[0] ? (15'h4000 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    i    = p[14:10];
    v0   = qsine(i);
    v1   = (i < 5'd16) ? qsine(i + 5'd1) : v0;
    prod = {10'd0, v1 - v0} * {15'd0, p[9:0]};
    v    = {1'b0, v0} + {1'b0, prod[24:10]};
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ===== rtl/core/led_strip_effect_pixel_generator_unit.sv =====
// Top level of the LED strip effect pixel generator: an eleven-stage pixel pipeline.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_req_type, in_elapsed_ms, in_led_index
//   out_     output     out_valid/out_ready out_red, out_green, out_blue
//   cfg_     input      cfg_wr_en          cfg_wr_data (led_count)
//
// A new transaction can enter every cycle while the output is not stalled, so the sustained rate is one
// pixel per cycle. The stages hold the chain of constant multiplications (period reduction, phase,
// smoothstep, bar, sine, brightness, channel scaling).
// Reset clears only the stage valid bits and led_count (back to 32); payload registers are not reset.
// Each stage advances when it is empty or its successor advances, so a stall at the output
// holds every occupied stage in place and bubbles are squeezed out behind it.
module led_strip_effect_pixel_generator_unit
  import lsepg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [31:0] in_elapsed_ms,
  input  logic [7:0] in_led_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] led_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= 8'd32;
    end else if (cfg_wr_en) begin
      led_count_r <= cfg_wr_data;
    end
  end

  // Center/last LED; user must keep the configuration quiet while pixels are in flight (not enforced).
  logic [6:0] center;
  logic [7:0] last_led;
  assign center   = led_count_r[7:1];
  assign last_led = led_count_r - 8'd1;

  // Stage valid bits and the advance chain.
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Control that rides along with each pixel.
  req_type_t typ_r [STAGES-1];
  logic [7:0] idx_r [STAGES-1];
  logic       off_r [STAGES-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      typ_r[0] <= req_type_t'(in_req_type);
      idx_r[0] <= in_led_index;
      off_r[0] <= (in_led_index >= led_count_r);
    end
    for (int k = 1; k < STAGES - 1; k++) begin
      if (en[k]) begin
        typ_r[k] <= typ_r[k-1];
        idx_r[k] <= idx_r[k-1];
        off_r[k] <= off_r[k-1];
      end
    end
  end

  // Stage 1: fold the four bytes of the elapsed time, each weighted by 256^k mod P.
  per_sel_t    sel_nxt;
  logic [21:0] y_nxt;
  per_sel_t    sel_s1_r;
  logic [21:0] y_s1_r;

  always_comb begin
    case (req_type_t'(in_req_type)) inside
      REQ_AMBIENT:                 sel_nxt = PER_3000;
      REQ_NAV_LEFT, REQ_NAV_RIGHT: sel_nxt = PER_1050;
      default:                     sel_nxt = PER_800;
    endcase
    y_nxt = {14'd0, in_elapsed_ms[7:0]}
          + {6'd0, in_elapsed_ms[15:8], 8'd0}
          + {2'd0, 20'({12'd0, in_elapsed_ms[23:16]} * {8'd0, res2_of(sel_nxt)})}
          + {2'd0, 20'({12'd0, in_elapsed_ms[31:24]} * {8'd0, res3_of(sel_nxt)})};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sel_s1_r <= sel_nxt;
      y_s1_r   <= y_nxt;
    end
  end

  // Stage 2: quotient estimate by the period's reciprocal.
  logic [44:0] qprod;
  per_sel_t    sel_s2_r;
  logic [21:0] y_s2_r;
  logic [11:0] q_s2_r;

  assign qprod = {23'd0, y_s1_r} * {22'd0, rcp_of(sel_s1_r)};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sel_s2_r <= sel_s1_r;
      y_s2_r   <= y_s1_r;
      q_s2_r   <= qprod[43:32];
    end
  end

  // Stage 3: remainder with one correcting subtraction.
  logic [11:0] per_s2;
  logic [23:0] qp;
  logic [21:0] rem_full;
  logic [11:0] m_nxt;
  per_sel_t    sel_s3_r;
  logic [11:0] m_s3_r;

  always_comb begin
    per_s2   = period_of(sel_s2_r);
    qp       = {12'd0, q_s2_r} * {12'd0, per_s2};
    rem_full = y_s2_r - qp[21:0];
    m_nxt    = (rem_full >= {10'd0, per_s2}) ? 12'(rem_full - {10'd0, per_s2})
                                              : rem_full[11:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sel_s3_r <= sel_s2_r;
      m_s3_r   <= m_nxt;
    end
  end

  // Stage 4: Q0.16 fraction of the period (or of the slide / fade window).
  // Blinkers: ms mod 800 decides the lit half of each 400 ms cycle.
  logic        slide_nxt;
  logic [11:0] fx;
  logic [32:0] fc;
  logic [44:0] fprod;
  logic        lit_nxt;
  logic [16:0] frac_s4_r;
  logic        slide_s4_r;
  logic        lit_s4_r;

  always_comb begin
    slide_nxt = (m_s3_r < NAV_SLIDE_MS);
    case (typ_r[2]) inside
      REQ_AMBIENT: begin
        fx = m_s3_r;
        fc = FRC_3000;
      end
      REQ_NAV_LEFT, REQ_NAV_RIGHT: begin
        fx = slide_nxt ? m_s3_r : (PERIOD_NAV - m_s3_r);
        fc = slide_nxt ? FRC_819 : FRC_231;
      end
      default: begin
        fx = m_s3_r;
        fc = FRC_800;
      end
    endcase
    fprod   = {33'd0, fx} * {12'd0, fc};
    lit_nxt = (m_s3_r < BLINK_ON_MS)
           || ((m_s3_r >= BLINK_HALF_MS) && (m_s3_r < (BLINK_HALF_MS + BLINK_ON_MS)));
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      frac_s4_r  <= fprod[40:24];
      slide_s4_r <= slide_nxt;
      lit_s4_r   <= lit_nxt;
    end
  end

  // Stage 5: t squared for the smoothstep, and the quadratic fade.
  logic [31:0] tt;
  logic [33:0] uu;
  logic [15:0] ph_s5_r;
  logic [15:0] t2_s5_r;
  logic [16:0] fade_s5_r;
  logic        slide_s5_r;
  logic        lit_s5_r;

  assign tt = frac_s4_r[15:0] * frac_s4_r[15:0];
  assign uu = {17'd0, frac_s4_r} * {17'd0, frac_s4_r};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ph_s5_r    <= frac_s4_r[15:0];
      t2_s5_r    <= tt[31:16];
      fade_s5_r  <= slide_s4_r ? 17'h10000 : uu[32:16];
      slide_s5_r <= slide_s4_r;
      lit_s5_r   <= lit_s4_r;
    end
  end

  // Stage 6: smoothstep = t^2 * (3 - 2t).
  logic [17:0] ssw;
  logic [33:0] ssprod;
  logic [15:0] ph_s6_r;
  logic [17:0] s_s6_r;
  logic [16:0] fade_s6_r;
  logic        slide_s6_r;
  logic        lit_s6_r;

  assign ssw    = 18'd196608 - {1'b0, ph_s5_r, 1'b0};
  assign ssprod = {18'd0, t2_s5_r} * {16'd0, ssw};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ph_s6_r    <= ph_s5_r;
      s_s6_r     <= ssprod[33:16];
      fade_s6_r  <= fade_s5_r;
      slide_s6_r <= slide_s5_r;
      lit_s6_r   <= lit_s5_r;
    end
  end

  // Stage 7: bar position in Q8.8, eased from the center toward the edge.
  logic        go_right;
  logic [7:0]  span;
  logic [25:0] bprod;
  logic [17:0] bar_nxt;
  logic [15:0] ph_s7_r;
  logic [17:0] bar_s7_r;
  logic [16:0] fade_s7_r;
  logic        lit_s7_r;

  always_comb begin
    go_right = (typ_r[5] == REQ_NAV_RIGHT);
    span     = go_right ? (last_led - {1'b0, center}) : {1'b0, center};
    bprod    = {18'd0, span} * {8'd0, s_s6_r};
    if (slide_s6_r) begin
      bar_nxt = go_right ? ({3'd0, center, 8'd0} + bprod[25:8])
                         : ({3'd0, center, 8'd0} - bprod[25:8]);
    end else begin
      bar_nxt = go_right ? {2'd0, last_led, 8'd0} : 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      ph_s7_r   <= ph_s6_r;
      bar_s7_r  <= bar_nxt;
      fade_s7_r <= fade_s6_r;
      lit_s7_r  <= lit_s6_r;
    end
  end

  // Stage 8: distance from the bar, and its position across the bar as Q0.16.
  logic [17:0] pos;
  logic [17:0] bar_dist;
  logic [40:0] cprod;
  logic [15:0] ph_s8_r;
  logic [15:0] ct_s8_r;
  logic        dark_s8_r;
  logic [16:0] fade_s8_r;
  logic        lit_s8_r;

  always_comb begin
    pos      = {2'd0, idx_r[6], 8'd0};
    bar_dist = (pos > bar_s7_r) ? (pos - bar_s7_r) : (bar_s7_r - pos);
    cprod    = {29'd0, bar_dist[11:0]} * {12'd0, CT_RCP};
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      ph_s8_r   <= ph_s7_r;
      ct_s8_r   <= cprod[39:24];
      dark_s8_r <= (bar_dist >= 18'd2304);
      fade_s8_r <= fade_s7_r;
      lit_s8_r  <= lit_s7_r;
    end
  end

  // Stage 9: the one sine lookup, shared by all effects that need it.
  logic [15:0]        arg;
  logic signed [16:0] cs_s9_r;
  logic [15:0]        ct_s9_r;
  logic               dark_s9_r;
  logic [16:0]        fade_s9_r;
  logic               lit_s9_r;

  always_comb begin
    case (typ_r[7]) inside
      REQ_NAV_LEFT, REQ_NAV_RIGHT: arg = {1'b0, ct_s8_r[15:1]} + 16'h4000;
      REQ_STRAIGHT:                arg = {1'b0, ph_s8_r[15:1]};
      default:                     arg = ph_s8_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      cs_s9_r   <= sine_q15(arg);
      ct_s9_r   <= ct_s8_r;
      dark_s9_r <= dark_s8_r;
      fade_s9_r <= fade_s8_r;
      lit_s9_r  <= lit_s8_r;
    end
  end

  // Stage 10: gray level for ambient and straight, brightness for the nav bar.
  logic [24:0] cs_ext;
  logic [24:0] amb_num;
  logic [15:0] amb_prod;
  logic [22:0] st_prod;
  logic [7:0]  st_q;
  logic [15:0] st_rem;
  logic [8:0]  st_val;
  logic [16:0] env_sum;
  logic [31:0] br_prod;
  logic [7:0]  gray_nxt;
  logic [7:0]  gray_s10_r;
  logic [16:0] bright_s10_r;
  logic [15:0] ct_s10_r;
  logic        dark_s10_r;
  logic        lit_s10_r;

  always_comb begin
    cs_ext   = {{8{cs_s9_r[16]}}, cs_s9_r};
    amb_num  = 25'd4194304 + (cs_ext << 7) - cs_ext;
    amb_prod = amb_num[22:15] * 8'd205;
    st_prod  = {cs_s9_r[14:0], 8'd0} - {8'd0, cs_s9_r[14:0]};
    st_q     = st_prod[22:15];
    st_rem   = {1'b0, st_prod[14:0]} + {8'd0, st_q};
    st_val   = (st_rem >= 16'd32767) ? ({1'b0, st_q} + 9'd1) : {1'b0, st_q};
    env_sum  = cs_s9_r + 17'h08000;
    br_prod  = {17'd0, env_sum[15:1]} * {15'd0, fade_s9_r};
    gray_nxt = (typ_r[8] == REQ_STRAIGHT) ? st_val[7:0] : {2'd0, amb_prod[15:10]};
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      gray_s10_r   <= gray_nxt;
      bright_s10_r <= br_prod[31:15];
      ct_s10_r     <= ct_s9_r;
      dark_s10_r   <= dark_s9_r;
      lit_s10_r    <= lit_s9_r;
    end
  end

  // Stage 11 (output register): bar colour scaled by brightness, and the final choice.
  logic [23:0] base_r;
  logic [23:0] base_g;
  logic [23:0] base_b;
  logic [40:0] pr_r;
  logic [40:0] pr_g;
  logic [40:0] pr_b;
  logic        half_lit;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;

  always_comb begin
    base_r = 24'd7864320 + ({8'd0, ct_s10_r} * 24'd135);
    base_g = {8'd0, ct_s10_r} * 24'd80;
    base_b = 24'd14417920 - ({8'd0, ct_s10_r} * 24'd35);
    pr_r   = {17'd0, base_r} * {24'd0, bright_s10_r};
    pr_g   = {17'd0, base_g} * {24'd0, bright_s10_r};
    pr_b   = {17'd0, base_b} * {24'd0, bright_s10_r};

    case (typ_r[9]) inside
      REQ_BLINK_LEFT:  half_lit = lit_s10_r && (idx_r[9] < {1'b0, center});
      REQ_BLINK_RIGHT: half_lit = lit_s10_r && (idx_r[9] >= {1'b0, center});
      default:         half_lit = lit_s10_r;
    endcase

    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    case (typ_r[9]) inside
      REQ_AMBIENT, REQ_STRAIGHT: begin
        red_nxt   = gray_s10_r;
        green_nxt = gray_s10_r;
        blue_nxt  = gray_s10_r;
      end
      REQ_NAV_LEFT, REQ_NAV_RIGHT: begin
        if (!dark_s10_r) begin
          red_nxt   = pr_r[39:32];
          green_nxt = pr_g[39:32];
          blue_nxt  = pr_b[39:32];
        end
      end
      REQ_BLINK_LEFT, REQ_BLINK_RIGHT, REQ_HAZARD: begin
        if (half_lit) begin
          red_nxt   = 8'd255;
          green_nxt = 8'd160;
        end
      end
      default: begin
        red_nxt = 8'd0;
      end
    endcase

    // An LED beyond the end of the strip is always dark.
    if (off_r[9]) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // An empty output register lets the whole pipeline move, so input must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while the pipeline output is empty");

  // An accepted transaction always lands in the first stage.
  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted transaction missing from stage one");

  // The modulo unit must leave a value below the selected period.
  a_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (m_s3_r < period_of(sel_s3_r)))
    else $error("period reduction out of range");

  // The fade never exceeds one in Q0.16.
  a_fade_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (fade_s5_r <= 17'h10000))
    else $error("fade above unity");

endmodule
